FILE: rtl/assert_macros.svh
// Assertion helpers for the speed meter. Each use takes a label and a property
// that holds no top-level comma; the clock is clk and reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset, with a fixed message.
`define EPSM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("speed meter assertion failed");

// Check a property on every rising edge outside reset, with a caller message.
`define EPSM_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

FILE: rtl/epsm_pkg.sv
package epsm_pkg;

    // Field and state widths
    localparam int SPEED_WIDTH  = 16;
    localparam int CAP_WIDTH    = 16;
    localparam int CNT_WIDTH    = 8;
    localparam int TICKS_WIDTH  = 16;
    localparam int NUM_WIDTH    = 24;
    localparam int PERIOD_WIDTH = 24;
    localparam int CFG_WIDTH    = 24;
    localparam int INDEX_WIDTH  = 2;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_WIDTH = ((CAP_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((SPEED_WIDTH + 7) / 8) * 8;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS  = NUM_WIDTH;
    localparam int STEP_WIDTH = $clog2(DIV_STEPS);
    localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(DIV_STEPS - 1);

    // Saturation limits
    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = {SPEED_WIDTH{1'b1}};
    localparam logic [32:0] SPEED_MAX_EXT = (33'd1 << SPEED_WIDTH) - 33'd1;
    localparam logic [CNT_WIDTH-1:0] CNT_MAX = {CNT_WIDTH{1'b1}};

    // Register indexes
    localparam logic [INDEX_WIDTH-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_TICKS   = 2'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_NUMER   = 2'd2;

    // Register reset values
    localparam logic [CNT_WIDTH-1:0]   TIMEOUT_RESET = 8'd30;
    localparam logic [TICKS_WIDTH-1:0] TICKS_RESET   = 16'd10000;
    localparam logic [NUM_WIDTH-1:0]   NUMER_RESET   = 24'd10000000;

    // Operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept_tick;
        logic accept_cap;
        logic mul_load;
        logic div_step;
        logic cap_commit;
        logic load_out;
    } epsm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
    } epsm_stat_t;

endpackage

FILE: rtl/epsm_ctrl.sv
module epsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               op,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  epsm_pkg::epsm_stat_t stat,
    output epsm_pkg::epsm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    // Decode commands and next state
    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == epsm_pkg::OP_CAPTURE)
                    begin
                        cmd.accept_cap = 1'b1;
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        cmd.accept_tick = 1'b1;
                        state_next      = ST_HOLD;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.cap_commit = 1'b1;
                state_next     = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/epsm_dp.sv
module epsm_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [epsm_pkg::INDEX_WIDTH-1:0]      wr_index,
    input  logic [epsm_pkg::CFG_WIDTH-1:0]        wr_data,
    input  logic [epsm_pkg::CAP_WIDTH-1:0]        capture_value,
    input  epsm_pkg::epsm_cmd_t                   cmd,
    output epsm_pkg::epsm_stat_t                  stat,
    output logic [epsm_pkg::SPEED_WIDTH-1:0]      speed,
    output logic                                  stopped
);

    // Configuration
    logic [epsm_pkg::CNT_WIDTH-1:0]    timeout_reg;
    logic [epsm_pkg::TICKS_WIDTH-1:0]  ticks_reg;
    logic [epsm_pkg::NUM_WIDTH-1:0]    numer_reg;

    // Wheel state
    logic [epsm_pkg::CNT_WIDTH-1:0]    ovf_reg;
    logic [epsm_pkg::SPEED_WIDTH-1:0]  speed_value_reg;
    logic                              stopped_reg;

    // Period and divider
    logic [epsm_pkg::CAP_WIDTH-1:0]    cap_reg;
    logic [epsm_pkg::PERIOD_WIDTH-1:0] period_reg;
    logic [epsm_pkg::PERIOD_WIDTH-1:0] period_next;
    logic [epsm_pkg::NUM_WIDTH-1:0]    quot_reg;
    logic [epsm_pkg::PERIOD_WIDTH-1:0] rem_reg;
    logic [epsm_pkg::STEP_WIDTH-1:0]   step_reg;
    logic [epsm_pkg::PERIOD_WIDTH:0]   rem_shift;
    logic                              rem_ge;
    logic [32:0]                       quot_ext;
    logic [epsm_pkg::SPEED_WIDTH-1:0]  speed_sat;

    // Output register
    logic [epsm_pkg::SPEED_WIDTH-1:0]  out_speed_reg;
    logic                              out_stopped_reg;

    // Period from captured ticks plus whole overflow periods
    assign period_next = epsm_pkg::PERIOD_WIDTH'(cap_reg)
                       + (epsm_pkg::PERIOD_WIDTH'(ovf_reg)
                          * epsm_pkg::PERIOD_WIDTH'(ticks_reg));

    // One restoring division step
    assign rem_shift = {rem_reg, quot_reg[epsm_pkg::NUM_WIDTH-1]};
    assign rem_ge    = (rem_shift >= {1'b0, period_reg});

    // Saturate the quotient into the speed field
    assign quot_ext = 33'(quot_reg);
    always_comb
    begin
        if ((period_reg == '0) || (quot_ext > epsm_pkg::SPEED_MAX_EXT))
        begin
            speed_sat = epsm_pkg::SPEED_MAX;
        end
        else
        begin
            speed_sat = epsm_pkg::SPEED_WIDTH'(quot_ext);
        end
    end

    assign stat.div_last = (step_reg == epsm_pkg::LAST_STEP);
    assign speed         = out_speed_reg;
    assign stopped       = out_stopped_reg;

    // Configuration and wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= epsm_pkg::TIMEOUT_RESET;
            ticks_reg       <= epsm_pkg::TICKS_RESET;
            numer_reg       <= epsm_pkg::NUMER_RESET;
            ovf_reg         <= '0;
            speed_value_reg <= '0;
            stopped_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    epsm_pkg::REG_TIMEOUT: timeout_reg <= wr_data[epsm_pkg::CNT_WIDTH-1:0];
                    epsm_pkg::REG_TICKS:   ticks_reg   <= wr_data[epsm_pkg::TICKS_WIDTH-1:0];
                    epsm_pkg::REG_NUMER:   numer_reg   <= wr_data[epsm_pkg::NUM_WIDTH-1:0];
                    default:               ;
                endcase
            end
            if (cmd.accept_tick)
            begin
                // Drop to stopped once the count passes the timeout
                if (ovf_reg > timeout_reg)
                begin
                    ovf_reg         <= epsm_pkg::CNT_WIDTH'(1);
                    speed_value_reg <= '0;
                    stopped_reg     <= 1'b1;
                end
                else
                begin
                    if (ovf_reg != epsm_pkg::CNT_MAX)
                    begin
                        ovf_reg <= ovf_reg + epsm_pkg::CNT_WIDTH'(1);
                    end
                    stopped_reg <= 1'b0;
                end
            end
            if (cmd.cap_commit)
            begin
                ovf_reg         <= '0;
                speed_value_reg <= speed_sat;
                stopped_reg     <= 1'b0;
            end
        end
    end

    // Capture, period and divider iteration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            if (cmd.mul_load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + epsm_pkg::STEP_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_cap)
        begin
            cap_reg <= capture_value;
        end
        if (cmd.mul_load)
        begin
            period_reg <= period_next;
            quot_reg   <= numer_reg;
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= epsm_pkg::PERIOD_WIDTH'(rem_shift - {1'b0, period_reg});
            end
            else
            begin
                rem_reg <= rem_shift[epsm_pkg::PERIOD_WIDTH-1:0];
            end
            quot_reg <= {quot_reg[epsm_pkg::NUM_WIDTH-2:0], rem_ge};
        end
        if (cmd.load_out)
        begin
            out_speed_reg   <= speed_value_reg;
            out_stopped_reg <= stopped_reg;
        end
    end

endmodule

FILE: rtl/encoder_period_speed_meter.sv
// Encoder period speed meter for one wheel.
// Input stream: s_tuser carries the operation (0 overflow tick, 1 edge
// capture), s_tdata the capture value in ticks. A beat is taken when
// s_tvalid and s_tready are both high; one result beat follows each input.
// Output stream: m_tdata carries the speed in mm/s, m_tuser the stopped flag,
// set when an overflow tick forced the speed to zero by timeout.
// Configuration: wr_en writes wr_data into register wr_index (0 timeout in
// overflows, 1 ticks per overflow, 2 speed numerator); other indexes ignored.
// Throughput: one item at a time. An accepted overflow tick goes to the hold
// state, which loads the output register and raises output valid; a capture
// first forms the period in the multiply-add, runs the restoring divider at
// one quotient bit per cycle, then saturates and commits before the hold
// state loads the output register.
// The output register holds its beat while m_tready is low; the next input is
// taken once the result has moved into it, so a stalled receiver stops the
// input after one pending item.
// Reset clears the overflow count and speed to zero and loads register
// defaults 30, 10000 and 10000000.
`include "assert_macros.svh"

module encoder_period_speed_meter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [epsm_pkg::S_TDATA_WIDTH-1:0]  s_tdata,  // [15:0] capture_value
    input  logic                                s_tuser,  // [0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [epsm_pkg::M_TDATA_WIDTH-1:0]  m_tdata,  // [15:0] speed
    output logic                                m_tuser,  // [0] stopped
    input  logic                                wr_en,
    input  logic [epsm_pkg::INDEX_WIDTH-1:0]    wr_index,
    input  logic [epsm_pkg::CFG_WIDTH-1:0]      wr_data
);

    epsm_pkg::epsm_cmd_t                 cmd;
    epsm_pkg::epsm_stat_t                stat;
    logic [epsm_pkg::SPEED_WIDTH-1:0]    speed;
    logic                                tick_fire;

    epsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    epsm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .capture_value (s_tdata[epsm_pkg::CAP_WIDTH-1:0]),
        .cmd           (cmd),
        .stat          (stat),
        .speed         (speed),
        .stopped       (m_tuser)
    );

    // Pad the speed up to whole bytes
    assign m_tdata = epsm_pkg::M_TDATA_WIDTH'(speed);

    // Overflow tick taken on the input
    assign tick_fire = s_tvalid && s_tready && (s_tuser == epsm_pkg::OP_TICK);

    // Checks
    `EPSM_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready)
    `EPSM_ASSERT_MSG(a_tick_latency, (tick_fire && !m_tvalid) |-> ##2 m_tvalid, "tick result late")
    `EPSM_ASSERT_MSG(a_stopped_zero, (m_tvalid && m_tuser) |-> (speed == '0), "stop with speed")

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam logic [epsm_pkg::INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                           op;
        logic [epsm_pkg::CAP_WIDTH-1:0] cap;
    } wheel_item_t;

    typedef struct packed {
        logic [epsm_pkg::SPEED_WIDTH-1:0] speed;
        logic                             stopped;
    } speed_beat_t;

    // DUT connections
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [epsm_pkg::S_TDATA_WIDTH-1:0] s_tdata = '0;   // [15:0] capture_value
    logic                               s_tuser = 1'b0; // [0] operation
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [epsm_pkg::M_TDATA_WIDTH-1:0] m_tdata;        // [15:0] speed
    logic                               m_tuser;        // [0] stopped
    logic                               wr_en = 1'b0;
    logic [epsm_pkg::INDEX_WIDTH-1:0]   wr_index = '0;
    logic [epsm_pkg::CFG_WIDTH-1:0]     wr_data = '0;

    // Predictor copy of the registers and wheel state
    logic [epsm_pkg::CNT_WIDTH-1:0]   cfg_timeout = epsm_pkg::TIMEOUT_RESET;
    logic [epsm_pkg::TICKS_WIDTH-1:0] cfg_ticks   = epsm_pkg::TICKS_RESET;
    logic [epsm_pkg::NUM_WIDTH-1:0]   cfg_numer   = epsm_pkg::NUMER_RESET;
    logic [epsm_pkg::CNT_WIDTH-1:0]   wheel_ovf   = '0;
    logic [epsm_pkg::SPEED_WIDTH-1:0] wheel_speed = '0;

    wheel_item_t pending_items[$];
    speed_beat_t speed_due[$];

    int  idle_pct = 0;
    int  items_queued = 0;
    int  items_taken = 0;
    int  captures_taken = 0;
    int  stops_seen = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  in_fire = 1'b0;

    encoder_period_speed_meter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // Advance the wheel state by one item and return the speed beat it produces
    function automatic speed_beat_t wheel_speed_step(
        input logic                           op,
        input logic [epsm_pkg::CAP_WIDTH-1:0] cap);
        speed_beat_t beat;
        logic [31:0] period;
        logic [31:0] quot;
        beat.stopped = 1'b0;
        if (op == epsm_pkg::OP_TICK)
        begin
            if (wheel_ovf > cfg_timeout)
            begin
                wheel_ovf     = epsm_pkg::CNT_WIDTH'(1);
                wheel_speed   = '0;
                beat.stopped  = 1'b1;
            end
            else if (wheel_ovf != epsm_pkg::CNT_MAX)
            begin
                wheel_ovf = wheel_ovf + epsm_pkg::CNT_WIDTH'(1);
            end
        end
        else
        begin
            period = 32'(cap) + 32'(wheel_ovf) * 32'(cfg_ticks);
            if (period == 32'd0)
            begin
                wheel_speed = epsm_pkg::SPEED_MAX;
            end
            else
            begin
                quot = 32'(cfg_numer) / period;
                wheel_speed = (quot > 32'(epsm_pkg::SPEED_MAX)) ? epsm_pkg::SPEED_MAX
                                                                : quot[epsm_pkg::SPEED_WIDTH-1:0];
            end
            wheel_ovf = '0;
        end
        beat.speed = wheel_speed;
        return beat;
    endfunction

    // Sender: present the next pending item, with random gaps between beats
    int send_gap = 0;
    always @(negedge clk)
    begin
        wheel_item_t item;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                send_gap = $urandom_range(16);
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= item.op;
                s_tdata  <= epsm_pkg::S_TDATA_WIDTH'(item.cap);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: hold off m_tready in random bursts
    int hold_gap = 0;
    always @(negedge clk)
    begin
        if (hold_gap > 0)
        begin
            hold_gap--;
            m_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            hold_gap = $urandom_range(16);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on each input beat, check each output beat
    always @(posedge clk)
    begin
        speed_beat_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycles, results_seen, items_queued);
            $display("** encoder_period_speed_meter: FAILED **");
            $finish;
        end
        else
        begin
            in_fire = rst_n && s_tvalid && s_tready;
            if (in_fire)
            begin
                speed_due.push_back(wheel_speed_step(s_tuser,
                                                     s_tdata[epsm_pkg::CAP_WIDTH-1:0]));
                items_taken++;
                if (s_tuser == epsm_pkg::OP_CAPTURE)
                    captures_taken++;
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                if (speed_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: speed %0d stopped %0b",
                                 m_tdata[epsm_pkg::SPEED_WIDTH-1:0], m_tuser);
                end
                else
                begin
                    want = speed_due.pop_front();
                    if (want.stopped)
                        stops_seen++;
                    if (m_tdata[epsm_pkg::SPEED_WIDTH-1:0] !== want.speed
                        || m_tuser !== want.stopped)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result %0d: expected speed %0d stopped %0b, got %0d %0b",
                                     results_seen, want.speed, want.stopped,
                                     m_tdata[epsm_pkg::SPEED_WIDTH-1:0], m_tuser);
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic op, input logic [epsm_pkg::CAP_WIDTH-1:0] cap);
        wheel_item_t item;
        item.op  = op;
        item.cap = cap;
        pending_items.push_back(item);
        items_queued++;
    endtask

    // Let the block run dry: every queued item answered
    task automatic drain();
        while (results_seen != items_queued)
        begin
            @(posedge clk);
            #1;
        end
        repeat (4) @(posedge clk);
        #1;
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [epsm_pkg::INDEX_WIDTH-1:0] idx,
                             input logic [epsm_pkg::CFG_WIDTH-1:0]   val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            epsm_pkg::REG_TIMEOUT: cfg_timeout = val[epsm_pkg::CNT_WIDTH-1:0];
            epsm_pkg::REG_TICKS:   cfg_ticks   = val[epsm_pkg::TICKS_WIDTH-1:0];
            epsm_pkg::REG_NUMER:   cfg_numer   = val[epsm_pkg::NUM_WIDTH-1:0];
            default:               ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [epsm_pkg::CNT_WIDTH-1:0]   tmo,
                              input logic [epsm_pkg::TICKS_WIDTH-1:0] tpo,
                              input logic [epsm_pkg::NUM_WIDTH-1:0]   num);
        write_reg(epsm_pkg::REG_TIMEOUT, epsm_pkg::CFG_WIDTH'(tmo));
        write_reg(epsm_pkg::REG_TICKS, epsm_pkg::CFG_WIDTH'(tpo));
        write_reg(epsm_pkg::REG_NUMER, epsm_pkg::CFG_WIDTH'(num));
        @(posedge clk);
        #1;
    endtask

    task automatic queue_ticks(input int count);
        for (int i = 0; i < count; i++)
            queue_item(epsm_pkg::OP_TICK, epsm_pkg::CAP_WIDTH'($urandom));
    endtask

    // Random traffic: runs of ticks closed by a capture, with some noise
    task automatic queue_traffic(input int count);
        int n;
        int run;
        logic [epsm_pkg::CAP_WIDTH-1:0] cap;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_item(logic'($urandom_range(1)), epsm_pkg::CAP_WIDTH'($urandom));
                n++;
            end
            else
            begin
                run = (cfg_timeout <= 40) ? $urandom_range(cfg_timeout + 3) : $urandom_range(6);
                queue_ticks(run);
                case ($urandom_range(7))
                    0:       cap = '0;
                    1:       cap = '1;
                    2:       cap = epsm_pkg::CAP_WIDTH'($urandom_range(255));
                    default: cap = epsm_pkg::CAP_WIDTH'($urandom);
                endcase
                queue_item(epsm_pkg::OP_CAPTURE, cap);
                n += run + 1;
            end
        end
    endtask

    initial
    begin
        logic [epsm_pkg::CNT_WIDTH-1:0]   tmo;
        logic [epsm_pkg::TICKS_WIDTH-1:0] tpo;
        logic [epsm_pkg::NUM_WIDTH-1:0]   num;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // Reset defaults: zero period, longest capture, tiny period, short tick run
        queue_item(epsm_pkg::OP_CAPTURE, 16'd0);
        queue_item(epsm_pkg::OP_CAPTURE, 16'hFFFF);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd1);
        queue_ticks(2);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd5000);
        drain();

        // Zero timeout, widest ticks and numerator; spare index must be ignored
        set_config(8'd0, 16'hFFFF, 24'hFFFFFF);
        write_reg(REG_SPARE, 24'hA5A5A5);
        idle_pct = 8;
        queue_ticks(3);
        queue_item(epsm_pkg::OP_CAPTURE, 16'hFFFF);
        queue_item(epsm_pkg::OP_CAPTURE, 16'hAAAA);
        queue_item(epsm_pkg::OP_CAPTURE, 16'h5555);
        drain();

        // Zero ticks per overflow and zero numerator
        set_config(8'd0, 16'd0, 24'd0);
        queue_item(epsm_pkg::OP_TICK, 16'h1234);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd0);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd7);
        queue_ticks(2);
        drain();

        // Smallest nonzero settings
        set_config(8'd1, 16'd1, 24'd1);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd1);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd2);
        queue_ticks(3);
        queue_item(epsm_pkg::OP_CAPTURE, 16'hFFFF);
        drain();

        // Count pinned at its maximum with the largest timeout, then largest period
        set_config(8'd255, 16'hFFFF, 24'hFFFFFF);
        queue_ticks(258);
        queue_item(epsm_pkg::OP_CAPTURE, 16'hFFFF);
        queue_item(epsm_pkg::OP_CAPTURE, 16'd0);
        queue_ticks(2);
        drain();

        // Random settings and traffic; some phases and the last one without idling
        for (int p = 0; p < 9; p++)
        begin
            case ($urandom_range(3))
                0:       tmo = 8'd0;
                1:       tmo = 8'd255;
                default: tmo = epsm_pkg::CNT_WIDTH'($urandom_range(1, 40));
            endcase
            case ($urandom_range(3))
                0:       tpo = 16'd1;
                1:       tpo = 16'hFFFF;
                2:       tpo = epsm_pkg::TICKS_WIDTH'($urandom_range(1, 65535));
                default: tpo = epsm_pkg::TICKS_WIDTH'($urandom_range(1, 2000));
            endcase
            case ($urandom_range(3))
                0:       num = 24'hFFFFFF;
                1:       num = epsm_pkg::NUM_WIDTH'($urandom_range(1, 24'hFFFFFF));
                2:       num = epsm_pkg::NUM_WIDTH'($urandom_range(1, 100000));
                default: num = epsm_pkg::NUM_WIDTH'($urandom_range(1000000, 24'hFFFFFF));
            endcase
            set_config(tmo, tpo, num);
            idle_pct = (p == 8 || p % 3 == 1) ? 0 : 8;
            queue_traffic(100);
            drain();
        end

        repeat (40) @(posedge clk);
        #1;
        if (speed_due.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", speed_due.size());
        end

        $display("Covered %0d items (%0d captures) over %0d register settings,",
                 items_taken, captures_taken, 14);
        $display("%0d results checked, %0d timeout stops, %0d mismatches",
                 results_seen, stops_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("** encoder_period_speed_meter: PASSED **");
        end
        else
        begin
            $display("** encoder_period_speed_meter: FAILED **");
        end
        $finish;
    end

endmodule
